// ===== src/crlm_pkg.sv =====
// Shared types and constants for the corner response local maximum unit.
`timescale 1ns / 1ps

package crlm_pkg;

  // Normalized level: 0..100 with 8 fraction bits.
  localparam int LEVEL_W = 15;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd25600;

  // Output coordinate width, fixed by the result format.
  localparam int COORD_W = 10;

  // Queue entry fields other than the line store address:
  // judge flag, level, output row, output column.
  localparam int META_W = 1 + LEVEL_W + COORD_W + COORD_W;

  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_OFFSET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESP_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd4;

  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic [10:0] frame_width;
    logic [10:0] frame_height;
    logic [31:0] resp_offset;
    logic [31:0] resp_scale;
    logic [6:0]  threshold;
  } cfg_t;

  localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [10:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [31:0] RST_RESP_OFFSET  = 32'd0;
  localparam logic [31:0] RST_RESP_SCALE   = 32'd65536;
  localparam logic [6:0]  RST_THRESHOLD    = 7'd20;

endpackage

// ===== src/crlm_in_if.sv =====
// Input request channel: raw response samples in raster order.
`timescale 1ns / 1ps

interface crlm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] response;
  logic        frame_start;

  modport source (output valid, output response, output frame_start, input ready);
  modport sink   (input valid, input response, input frame_start, output ready);
endinterface

// ===== src/crlm_out_if.sv =====
// Result request channel: one judgement per input sample.
`timescale 1ns / 1ps

interface crlm_out_if;
  logic        valid;
  logic        ready;
  logic        decided;
  logic        corner_found;
  logic [9:0]  centre_row;
  logic [9:0]  centre_col;
  logic [14:0] centre_level;

  modport source (output valid, output decided, output corner_found, output centre_row,
                  output centre_col, output centre_level, input ready);
  modport sink   (input valid, input decided, input corner_found, input centre_row,
                  input centre_col, input centre_level, output ready);
endinterface

// ===== src/crlm_queue.sv =====
// Small register queue between the front and back parts.
`timescale 1ns / 1ps

module crlm_queue #(
  parameter int W     = 46,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full  = (count_r == (PW+1)'(DEPTH));
  assign valid = (count_r != '0);
  assign rdata = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== src/crlm_front.sv =====
// Front part: accepts samples, tracks raster position and normalizes the level.
`timescale 1ns / 1ps

module crlm_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  crlm_in_if.sink             in_chan,
  input  crlm_pkg::cfg_t      cfg,
  input  logic                clear_busy,
  input  logic                q_full,
  output logic                q_push,
  output logic [crlm_pkg::META_W+$clog2(MAX_WIDTH)-1:0] q_wdata
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int CMPW = ((WW > HW) ? WW : HW) > 11 ? ((WW > HW) ? WW : HW) : 11;
  localparam int LW   = crlm_pkg::LEVEL_W;

  logic [CMPW-1:0] fw_ext, fh_ext;
  logic [WW-1:0]   width_eff;
  logic [HW-1:0]   height_eff;

  logic [RW-1:0]   row_cnt_r, row_cnt_nxt;
  logic [CW-1:0]   col_cnt_r, col_cnt_nxt;
  logic [RW-1:0]   cur_row;
  logic [CW-1:0]   cur_col;
  logic [CW:0]     col_inc;
  logic [RW:0]     row_inc;
  logic            judge;
  logic [RW-1:0]   row_m1;
  logic [CW-1:0]   col_m1;
  logic [31:0]     row_m1_ext, col_m1_ext;

  logic [32:0]     diff;
  logic            diff_pos;
  logic [63:0]     prod;

  logic            accept;
  logic            f_valid_r;
  logic [63:0]     prod_r;
  logic            pos_r;
  logic            judge_r;
  logic [9:0]      row_out_r, col_out_r;
  logic [CW-1:0]   col_r;
  logic [47:0]     prod_hi;
  logic [LW-1:0]   level;

  // Frame size saturated to the supported range.
  always_comb begin
    fw_ext = CMPW'(cfg.frame_width);
    fh_ext = CMPW'(cfg.frame_height);
    if (fw_ext < CMPW'(3)) begin
      width_eff = WW'(3);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(fw_ext);
    end
    if (fh_ext < CMPW'(3)) begin
      height_eff = HW'(3);
    end else if (fh_ext > CMPW'(MAX_HEIGHT)) begin
      height_eff = HW'(MAX_HEIGHT);
    end else begin
      height_eff = HW'(fh_ext);
    end
  end

  // Position of the incoming sample and the next position.
  always_comb begin
    cur_row = in_chan.frame_start ? '0 : row_cnt_r;
    cur_col = in_chan.frame_start ? '0 : col_cnt_r;
    col_inc = {1'b0, cur_col} + 1'b1;
    row_inc = {1'b0, cur_row} + 1'b1;
    if (col_inc >= (CW+1)'(width_eff)) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= (RW+1)'(height_eff)) ? '0 : row_inc[RW-1:0];
    end else begin
      col_cnt_nxt = col_inc[CW-1:0];
      row_cnt_nxt = cur_row;
    end
    judge = (cur_row >= RW'(2)) && (cur_col >= CW'(2)) &&
            (HW'(cur_row) < height_eff) && (WW'(cur_col) < width_eff);
    row_m1     = cur_row - 1'b1;
    col_m1     = cur_col - 1'b1;
    row_m1_ext = 32'(row_m1);
    col_m1_ext = 32'(col_m1);
  end

  // Offset subtraction is exact; only a positive difference is scaled.
  assign diff     = {in_chan.response[31], in_chan.response} -
                    {cfg.resp_offset[31], cfg.resp_offset};
  assign diff_pos = !diff[32] && (diff[31:0] != 32'd0);
  assign prod     = {32'd0, diff[31:0]} * {32'd0, cfg.resp_scale};

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !clear_busy && (!f_valid_r || !q_full);
  assign q_push        = f_valid_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      if (accept) begin
        f_valid_r <= 1'b1;
        row_cnt_r <= row_cnt_nxt;
        col_cnt_r <= col_cnt_nxt;
      end else if (q_push) begin
        f_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r    <= prod;
      pos_r     <= diff_pos;
      judge_r   <= judge;
      row_out_r <= row_m1_ext[9:0];
      col_out_r <= col_m1_ext[9:0];
      col_r     <= cur_col;
    end
  end

  // Shift by 16 and clamp to the full-scale level.
  assign prod_hi = prod_r[63:16];
  always_comb begin
    if (!pos_r) begin
      level = '0;
    end else if (prod_hi > 48'(crlm_pkg::LEVEL_MAX)) begin
      level = crlm_pkg::LEVEL_MAX;
    end else begin
      level = prod_hi[LW-1:0];
    end
  end

  assign q_wdata = {judge_r, level, row_out_r, col_out_r, col_r};

endmodule

// ===== src/crlm_back.sv =====
// Back part: line stores, 3x3 window, local maximum test and result register.
`timescale 1ns / 1ps

module crlm_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          threshold,
  input  logic                q_valid,
  input  logic [crlm_pkg::META_W+$clog2(MAX_WIDTH)-1:0] q_rdata,
  output logic                q_pop,
  output logic                clear_busy,
  crlm_out_if.source          out_chan
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = crlm_pkg::LEVEL_W;

  logic [CW-1:0] q_col;
  logic [9:0]    q_col_out, q_row_out;
  logic [LW-1:0] q_level;
  logic          q_judge;

  logic [LW-1:0] upper_mem  [MAX_WIDTH];
  logic [LW-1:0] middle_mem [MAX_WIDTH];

  logic          clr_r;
  logic [CW-1:0] clr_addr_r;

  logic          b1_valid_r, b1_judge_r, b1_fwd_r;
  logic [LW-1:0] b1_level_r, rd_up_r, rd_mid_r, fwd_top_r, fwd_mid_r;
  logic [9:0]    b1_row_r, b1_col_out_r;
  logic [CW-1:0] b1_col_r;
  logic          b1_adv;
  logic [LW-1:0] top_eff, mid_eff;

  logic          mem_we;
  logic [CW-1:0] mem_addr;
  logic [LW-1:0] mem_up_wd, mem_mid_wd;

  logic [LW-1:0] win1_r [3];
  logic [LW-1:0] win2_r [3];
  logic [LW-1:0] centre;
  logic [6:0]    cint;
  logic [LW-1:0] ctrunc;
  logic [LW-1:0] nbr [8];
  logic          found;

  logic          out_valid_r, out_dec_r, out_found_r;
  logic [9:0]    out_row_r, out_col_r;
  logic [LW-1:0] out_level_r;

  assign {q_judge, q_level, q_row_out, q_col_out, q_col} = q_rdata;

  assign clear_busy = clr_r;
  assign b1_adv     = b1_valid_r && (!out_valid_r || out_chan.ready);
  assign q_pop      = q_valid && !clr_r && (!b1_valid_r || b1_adv);

  // A sample read the cycle its column is being written takes the new values.
  assign top_eff = b1_fwd_r ? fwd_top_r : rd_up_r;
  assign mid_eff = b1_fwd_r ? fwd_mid_r : rd_mid_r;

  assign mem_we     = clr_r || b1_adv;
  assign mem_addr   = clr_r ? clr_addr_r : b1_col_r;
  assign mem_up_wd  = clr_r ? '0 : mid_eff;
  assign mem_mid_wd = clr_r ? '0 : b1_level_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[mem_addr]  <= mem_up_wd;
      middle_mem[mem_addr] <= mem_mid_wd;
    end
    if (q_pop) begin
      rd_up_r  <= upper_mem[q_col];
      rd_mid_r <= middle_mem[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (q_pop) begin
      b1_valid_r <= 1'b1;
    end else if (b1_adv) begin
      b1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_judge_r   <= q_judge;
      b1_level_r   <= q_level;
      b1_row_r     <= q_row_out;
      b1_col_out_r <= q_col_out;
      b1_col_r     <= q_col;
      b1_fwd_r     <= b1_adv && (q_col == b1_col_r);
      fwd_top_r    <= mid_eff;
      fwd_mid_r    <= b1_level_r;
    end
  end

  // Window columns: win1 is the oldest stored column, win2 the newer one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win1_r[i] <= '0;
        win2_r[i] <= '0;
      end
    end else if (b1_adv) begin
      for (int i = 0; i < 3; i++) begin
        win1_r[i] <= win2_r[i];
      end
      win2_r[0] <= top_eff;
      win2_r[1] <= mid_eff;
      win2_r[2] <= b1_level_r;
    end
  end

  // Centre after the shift is the middle of the newer stored column.
  always_comb begin
    centre = win2_r[1];
    cint   = centre[LW-1:8];
    ctrunc = {cint, 8'h00};
    nbr[0] = win1_r[0];
    nbr[1] = win1_r[1];
    nbr[2] = win1_r[2];
    nbr[3] = win2_r[0];
    nbr[4] = win2_r[2];
    nbr[5] = top_eff;
    nbr[6] = mid_eff;
    nbr[7] = b1_level_r;
    found  = cint > threshold;
    for (int i = 0; i < 8; i++) begin
      if (ctrunc <= nbr[i]) begin
        found = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_adv) begin
      out_dec_r   <= b1_judge_r;
      out_found_r <= b1_judge_r && found;
      out_row_r   <= b1_judge_r ? b1_row_r : '0;
      out_col_r   <= b1_judge_r ? b1_col_out_r : '0;
      out_level_r <= b1_judge_r ? centre : '0;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.decided      = out_dec_r;
  assign out_chan.corner_found = out_found_r;
  assign out_chan.centre_row   = out_row_r;
  assign out_chan.centre_col   = out_col_r;
  assign out_chan.centre_level = out_level_r;

`ifndef SYNTHESIS
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !q_pop)
    else $error("queue popped during line store clearing");

  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_r) |-> $past(clr_addr_r) == CW'(MAX_WIDTH - 1))
    else $error("line store clearing ended early");

  a_fwd_src: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && b1_adv && (q_col == b1_col_r) |=> b1_fwd_r && b1_valid_r)
    else $error("same-column request missed forwarding");

  a_undecided_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_dec_r |-> !out_found_r && (out_level_r == '0))
    else $error("undecided result carries data");
`endif

endmodule

// ===== src/corner_response_local_max_unit.sv =====
// Top level of the 3x3 corner response non-maximum suppression unit.
`timescale 1ns / 1ps

// Channel  | Direction | Payload
// ---------+-----------+---------------------------------------------------------
// in_chan  | sink      | response (s32), frame_start (1)
// out_chan | source    | decided, corner_found, centre_row, centre_col, centre_level
// cfg_*    | write     | cfg_we, cfg_index (3), cfg_data (32)
//
// Throughput is one request per clock while the result side takes results and
// no clearing pass runs; the rate is set by the single multiply stage in the
// front part and the one-read, one-write port of each line store. A sample
// passes the normalize register, queue, line store read and result register.
// After reset, a clearing pass zeroes both line stores; in_chan.ready stays
// low until it ends, while configuration writes are taken.
// A stalled result fills the four-entry queue before the input side stalls.

module corner_response_local_max_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  crlm_in_if.sink     in_chan,
  crlm_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [crlm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crlm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int ITEM_W = crlm_pkg::META_W + CW;

  crlm_pkg::cfg_t cfg_r;

  logic              q_push, q_pop, q_full, q_valid, clear_busy;
  logic [ITEM_W-1:0] q_wdata, q_rdata;

  // Configuration registers. Writes to indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= crlm_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height <= crlm_pkg::RST_FRAME_HEIGHT;
      cfg_r.resp_offset  <= crlm_pkg::RST_RESP_OFFSET;
      cfg_r.resp_scale   <= crlm_pkg::RST_RESP_SCALE;
      cfg_r.threshold    <= crlm_pkg::RST_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crlm_pkg::CFG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_data[10:0];
        crlm_pkg::CFG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_data[10:0];
        crlm_pkg::CFG_RESP_OFFSET:  cfg_r.resp_offset  <= cfg_data;
        crlm_pkg::CFG_RESP_SCALE:   cfg_r.resp_scale   <= cfg_data;
        crlm_pkg::CFG_THRESHOLD:    cfg_r.threshold    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // The front part stamps each sample with its position and whether its
  // centre is judged, then normalizes the level.
  crlm_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .cfg        (cfg_r),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  // The queue lets the result side stall without stopping the input at once.
  crlm_queue #(
    .W     (ITEM_W),
    .DEPTH (crlm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // The back part owns the line stores and the window, so every sample passes
  // through it in order, judged or not.
  crlm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .threshold  (cfg_r.threshold),
    .q_valid    (q_valid),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_chan   (out_chan)
  );

endmodule

// ===== dv/crlm_checker.sv =====
// Checker for the corner response unit: predicts every judgement and compares results.
`timescale 1ns / 1ps

module crlm_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  crlm_in_if                                  in_mon,
  crlm_out_if                                 out_mon,
  input  logic                                cfg_we,
  input  logic [crlm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crlm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int unsigned                         fail_count,
  output int unsigned                         pending
);

  localparam int LW      = crlm_pkg::LEVEL_W;
  localparam int COORD_W = crlm_pkg::COORD_W;

  typedef struct packed {
    logic               decided;
    logic               corner_found;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LW-1:0]      level;
  } judgement_t;

  crlm_pkg::cfg_t     regs;
  logic [LW-1:0]      upper_line [MAX_WIDTH];
  logic [LW-1:0]      middle_line [MAX_WIDTH];
  logic [LW-1:0]      win [3][3];
  int unsigned        row_pos;
  int unsigned        col_pos;
  judgement_t         judgement_q [$];

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  // Offset removal, fixed point scaling and clamping to 100.0.
  function automatic logic [LW-1:0] normalized_level(input logic [31:0] resp);
    logic signed [32:0] diff;
    logic [63:0]        prod;
    diff = $signed({resp[31], resp}) - $signed({regs.resp_offset[31], regs.resp_offset});
    if (diff <= 0) return '0;
    prod = (64'(diff[31:0]) * 64'(regs.resp_scale)) >> 16;
    return (prod > 64'(crlm_pkg::LEVEL_MAX)) ? crlm_pkg::LEVEL_MAX : prod[LW-1:0];
  endfunction

  function automatic judgement_t judge_sample(input logic [31:0] resp, input logic fs);
    int unsigned        w, h, r, c;
    logic [LW-1:0]      lvl, top_lv, mid_lv, centre, ctrunc;
    logic               found;
    judgement_t         res;
    w = clamp_dim(regs.frame_width, MAX_WIDTH);
    h = clamp_dim(regs.frame_height, MAX_HEIGHT);
    lvl = normalized_level(resp);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    top_lv = '0;
    mid_lv = '0;
    if (c < MAX_WIDTH) begin
      top_lv = upper_line[c];
      mid_lv = middle_line[c];
      upper_line[c] = mid_lv;
      middle_line[c] = lvl;
    end
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top_lv;
    win[1][2] = mid_lv;
    win[2][2] = lvl;

    res = '0;
    if (r >= 2 && c >= 2 && r < h && c < w) begin
      centre = win[1][1];
      ctrunc = {centre[LW-1:8], 8'h00};
      found = (centre >> 8) > regs.threshold;
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++)
          if (!(y == 1 && x == 1) && ctrunc <= win[y][x]) found = 1'b0;
      res.decided = 1'b1;
      res.corner_found = found;
      res.row = COORD_W'(r - 1);
      res.col = COORD_W'(c - 1);
      res.level = centre;
    end

    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return res;
  endfunction

  function automatic bit same_field(input string field, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    judgement_t got, want;
    bit         ok;
    if (!rst_n) begin
      regs.frame_width = crlm_pkg::RST_FRAME_WIDTH;
      regs.frame_height = crlm_pkg::RST_FRAME_HEIGHT;
      regs.resp_offset = crlm_pkg::RST_RESP_OFFSET;
      regs.resp_scale = crlm_pkg::RST_RESP_SCALE;
      regs.threshold = crlm_pkg::RST_THRESHOLD;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++) win[y][x] = '0;
      row_pos = 0;
      col_pos = 0;
      judgement_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crlm_pkg::CFG_FRAME_WIDTH:  regs.frame_width = cfg_data[10:0];
          crlm_pkg::CFG_FRAME_HEIGHT: regs.frame_height = cfg_data[10:0];
          crlm_pkg::CFG_RESP_OFFSET:  regs.resp_offset = cfg_data;
          crlm_pkg::CFG_RESP_SCALE:   regs.resp_scale = cfg_data;
          crlm_pkg::CFG_THRESHOLD:    regs.threshold = cfg_data[6:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        got.decided = out_mon.decided;
        got.corner_found = out_mon.corner_found;
        got.row = out_mon.centre_row;
        got.col = out_mon.centre_col;
        got.level = out_mon.centre_level;
        if (judgement_q.size() == 0) begin
          $error("result request with no sample waiting: row %0d col %0d level %0d",
                 got.row, got.col, got.level);
          fail_count++;
        end else begin
          want = judgement_q.pop_front();
          ok = same_field("decided", want.decided, got.decided);
          ok = same_field("corner_found", want.corner_found, got.corner_found) && ok;
          ok = same_field("centre_row", want.row, got.row) && ok;
          ok = same_field("centre_col", want.col, got.col) && ok;
          ok = same_field("centre_level", want.level, got.level) && ok;
          if (!ok) fail_count++;
        end
      end

      if (in_mon.valid && in_mon.ready)
        judgement_q.push_back(judge_sample(in_mon.response, in_mon.frame_start));
    end
    pending = judgement_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the corner response unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int IDX_W      = crlm_pkg::CFG_IDX_W;

  // Cycles without any accepted request before the run is declared hung. The
  // line store clearing pass after reset and the longest result stall both fit
  // well inside it.
  localparam int unsigned QUIET_LIMIT = 6000;

  // Raw response range that maps onto the full normalized scale, and the
  // whole 32-bit range for the cases where the scale cannot be inverted.
  localparam longint LEVEL_SPAN = 64'd1677721600;
  localparam longint SPAN_FULL  = 64'd4294967296;
  localparam longint RESP_MAX   = (longint'(1) <<< 31) - 1;
  localparam longint RESP_MIN   = -(longint'(1) <<< 31);

  localparam int NUM_PHASES = 16;

  logic clk = 1'b0;
  logic rst_n;
  logic                            cfg_we;
  logic [IDX_W-1:0]                cfg_index;
  logic [crlm_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                     fail_count;
  int unsigned                     pending;

  crlm_in_if  in_chan ();
  crlm_out_if out_chan ();

  always #10 clk = ~clk;

  corner_response_local_max_unit #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  crlm_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side flow control. The sink switches between patterns picked at random:
  // always ready, random stalls, a fixed periodic stall, or rare long stalls
  // that are long enough to fill the internal queue and push back on the input.
  int unsigned sink_cycle = 0;
  int unsigned sink_mode  = 0;
  int unsigned sink_hold  = 0;

  always @(negedge clk) begin
    sink_cycle++;
    if (sink_cycle % 256 == 0) sink_mode = $urandom_range(0, 3);
    case (sink_mode)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= ($urandom_range(0, 3) != 0);
      2: out_chan.ready <= ((sink_cycle % 7) >= 3);
      default: begin
        if (sink_hold != 0) sink_hold--;
        else if ($urandom_range(0, 19) == 0) sink_hold = $urandom_range(10, 60);
        out_chan.ready <= (sink_hold == 0);
      end
    endcase
  end

  // Watchdog: any request moving on either channel counts as progress.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Sender state: requests go out in bursts of random length. When
  // steady_feed is set, bursts follow each other with no gap at all.
  int unsigned burst_left  = 0;
  bit          steady_feed = 1'b0;
  longint      feed_base;
  longint      feed_span;

  // Drives one sample at the falling edge and holds it until the unit takes
  // it. Returns at the falling edge after acceptance, with valid still high,
  // so back to back requests never toggle valid inside one time step.
  task automatic send_sample(input logic [31:0] resp, input logic fs);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (!steady_feed)
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.response    <= resp;
    in_chan.frame_start <= fs;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits until every predicted judgement has come back,
  // then lets the pipeline settle before anything else happens.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Writes all five registers. Unused upper data bits carry random values,
  // since only the low bits of the narrow registers are meant to be kept.
  // Optionally also writes an index past the end of the register list.
  task automatic load_settings(input int unsigned w, input int unsigned h,
                               input logic [31:0] off, input logic [31:0] scl,
                               input int unsigned thr, input bit stray_write);
    logic [31:0] val;
    val = $urandom;
    val[10:0] = w[10:0];
    write_reg(crlm_pkg::CFG_FRAME_WIDTH, val);
    val = $urandom;
    val[10:0] = h[10:0];
    write_reg(crlm_pkg::CFG_FRAME_HEIGHT, val);
    write_reg(crlm_pkg::CFG_RESP_OFFSET, off);
    write_reg(crlm_pkg::CFG_RESP_SCALE, scl);
    val = $urandom;
    val[6:0] = thr[6:0];
    write_reg(crlm_pkg::CFG_THRESHOLD, val);
    if (stray_write)
      write_reg(IDX_W'($urandom_range(crlm_pkg::CFG_THRESHOLD + 1, 2 ** IDX_W - 1)),
                $urandom);
    cfg_we <= 1'b0;
    // Raw range that sweeps the normalized level from 0 up to full scale.
    feed_base = longint'($signed(off));
    if (scl == 0) begin
      feed_span = SPAN_FULL;
    end else begin
      feed_span = LEVEL_SPAN / longint'(scl) + 1;
      if (feed_span > SPAN_FULL) feed_span = SPAN_FULL;
    end
  endtask

  // Most samples land inside the range that the current offset and scale map
  // onto 0..100, some sit near the top to make clear peaks, some fall at or
  // below the offset, and the rest are raw 32-bit noise.
  function automatic logic [31:0] pick_response();
    longint unsigned rnd;
    longint          v;
    rnd = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: v = feed_base + feed_span - feed_span / 8 + longint'(rnd % (feed_span / 4 + 1));
      3: v = feed_base - longint'(rnd % (feed_span / 8 + 1));
      default: v = feed_base + longint'(rnd % (feed_span + 1));
    endcase
    if (v > RESP_MAX) v = RESP_MAX;
    else if (v < RESP_MIN) v = RESP_MIN;
    return v[31:0];
  endfunction

  task automatic send_block(input logic [31:0] vals [9], input bit fs_first);
    for (int i = 0; i < 9; i++) send_sample(vals[i], fs_first && i == 0);
  endtask

  // Directed 3x3 frames at unit scale, where the level equals the raw value
  // clamped to 0..25600. The centre is the fifth sample.
  // Clear corner: the centre saturates at full scale and every neighbour,
  // including the most negative and most positive raw values that stay below
  // it, is lower.
  logic [31:0] peak_frame [9] = '{32'h8000_0000, 32'd0, 32'd1, 32'd25599, 32'h7FFF_FFFF,
                                  32'hFFFF_FFFF, 32'd100, 32'd255, 32'd256};
  // Truncation tie: the centre holds 30.99 but only its integer part counts,
  // and one neighbour sits at exactly 30.0, so this is not a corner.
  logic [31:0] tie_frame [9] = '{32'd7000, 32'd7680, 32'd7000, 32'd7000, 32'd7935,
                                 32'd7000, 32'd0, 32'd7000, 32'd7000};

  initial begin
    int unsigned w, h, thr, n_items;
    logic [31:0] off, scl;
    bit          restart;

    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_chan.valid       = 1'b0;
    in_chan.response    = '0;
    in_chan.frame_start = 1'b0;
    out_chan.ready      = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Registers are taken during the clearing pass, so the first settings go
    // in right away; the first sample then waits for the input to open.
    load_settings(3, 3, 32'd0, 32'd65536, 20, 1'b0);

    // Directed part. The tie frame follows without a frame start, so it
    // relies on the position wrapping after the last pixel of the frame.
    // Then a frame start arrives mid-frame and pulls the position back.
    send_block(peak_frame, 1'b1);
    send_block(tie_frame, 1'b0);
    send_sample(32'd25600, 1'b0);
    send_sample(32'd12345, 1'b1);

    // Random phases. Every phase begins with the unit fully drained, which is
    // also where the sender holds off until all results are back. Phases that
    // do not restart the frame continue at the old position under the new
    // size, so positions past the new width or height are exercised too.
    for (int p = 0; p < NUM_PHASES; p++) begin
      w = $urandom_range(3, 16);
      h = $urandom_range(3, 12);
      off = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 200000)) - 100000;
      scl = 32'(LEVEL_SPAN / (longint'(1) <<< $urandom_range(7, 31)));
      thr = $urandom_range(0, 100);
      n_items = $urandom_range(45, 85);
      restart = ($urandom_range(0, 4) != 0);
      steady_feed = ($urandom_range(0, 3) == 0);
      case (p)
        0: begin
          w = 8;
          h = 6;
          off = 32'd0;
          scl = 32'd65536;
          thr = 20;
        end
        // Sizes below three clamp up; lowest offset with the smallest
        // nonzero scale; a threshold of zero.
        1: begin
          w = 0;
          h = 2;
          off = 32'h8000_0000;
          scl = 32'd1;
          thr = 0;
          restart = 1'b1;
        end
        // Widest frame: a width above the limit clamps to the line store
        // depth. Only part of the first row is sent, which leaves the column
        // far past the width of the next phase.
        2: begin
          w = 2047;
          h = MAX_HEIGHT;
          off = 32'd0;
          scl = 32'd65536;
          n_items = 200;
          restart = 1'b1;
        end
        // The width shrinks while the column sits far past it.
        3: begin
          w = 3;
          h = MAX_HEIGHT;
          n_items = 60;
          restart = 1'b0;
        end
        // The height shrinks while the row sits far past it.
        4: begin
          thr = 127;
          restart = 1'b0;
        end
        // Largest scale: every sample above the offset saturates, and a
        // threshold of 100 can never be exceeded.
        5: begin
          thr = 100;
          scl = 32'hFFFF_FFFF;
          off = 32'd0;
        end
        // Highest offset: no sample ends up above it.
        6: off = 32'h7FFF_FFFF;
        7: scl = 32'd0;
        default: ;
      endcase

      wait_idle();
      load_settings(w, h, off, scl, thr, (p % 3) == 0);
      for (int i = 0; i < n_items; i++)
        send_sample(pick_response(), (i == 0 && restart) || ($urandom_range(0, 199) == 0));
    end

    // Drain and let the pipeline run a few more cycles so that any stray
    // result still shows up before the verdict.
    wait_idle();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== corner_response_local_max_unit.f =====
src/crlm_pkg.sv
src/crlm_in_if.sv
src/crlm_out_if.sv
src/crlm_queue.sv
src/crlm_front.sv
src/crlm_back.sv
src/corner_response_local_max_unit.sv
dv/crlm_checker.sv
dv/tb_top.sv
